@@ design/aabb_projective_transform_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the box transform
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef AABB_PROJECTIVE_TRANSFORM_MACROS_SVH
`define AABB_PROJECTIVE_TRANSFORM_MACROS_SVH
`ifndef SYNTH
`define APT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define APT_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define APT_ASSERT(lbl, prop, msg)
`define APT_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

@@ design/aabbpt_pkg.sv @@
// ----------------------------------------------------------------------------
// Box transform package
// Payload types, register map and fixed-point constants.
// ----------------------------------------------------------------------------
package aabbpt_pkg;

	localparam int NUM_CFG    = 8;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_W      = 64;
	localparam int NUM_W      = 66;           // exact sum of four Q32.32 products
	localparam int DIVN_W     = NUM_W + 16;   // numerator scaled by 2^16
	localparam int QUOT_W     = 32;
	localparam int CMP_W      = NUM_W + QUOT_W;

	localparam logic [2:0] LAST_CORNER = 3'd7;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
		64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
		64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
	};

	typedef struct packed {
		logic signed [31:0] min_x;
		logic signed [31:0] min_y;
		logic signed [31:0] min_z;
		logic signed [31:0] max_x;
		logic signed [31:0] max_y;
		logic signed [31:0] max_z;
		logic               box_valid;
	} box_in_t;

	typedef struct packed {
		logic signed [31:0] new_min_x;
		logic signed [31:0] new_min_y;
		logic signed [31:0] new_min_z;
		logic signed [31:0] new_max_x;
		logic signed [31:0] new_max_y;
		logic signed [31:0] new_max_z;
		logic               result_valid;
		logic               divide_fault;
	} box_out_t;

	// travels with every corner down the pipe
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic box_valid;
	} corner_meta_t;

	typedef struct packed {
		logic neg;
		logic num_neg;
		logic num_zero;
		logic den_zero;
		logic ovf;
	} lane_flags_t;

endpackage

@@ design/aabb_projective_transform.sv @@
// ----------------------------------------------------------------------------
// Projective transform of an axis-aligned box
// Transforms eight corners by a 4x4 Q16.16 matrix, divides by w and reduces.
// ----------------------------------------------------------------------------
// Usage:
//   src_* carries one box word (src_data) under valid/stall; dst_* returns one
//   result word per box. cfg_* writes one 64-bit matrix register per
//   handshake (cfg_ready is always high); write only while the block is idle.
//   Indexes of 8 and above are ignored.
// Sequencing: the box is split into its eight corners and one corner
//   enters the pipeline per cycle while the pipe is not stalled; the
//   corner sequencer sets the rate.
// Pipeline: products, two adder stages, sign handling, an overflow check,
//   32 restoring divide stages (one quotient bit each), saturation, then
//   min/max reduction.
// Reset: matrix returns to identity, all pipeline valid bits clear.
// Stall: while dst_stall holds a waiting result the whole pipe freezes and
//   src_stall rises; nothing is lost or repeated. A new box is taken while
//   the last corner of the previous one is issued.
// ----------------------------------------------------------------------------
`include "aabb_projective_transform_macros.svh"

module aabb_projective_transform
	import aabbpt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_stall,
	input  box_in_t              src_data,
	output logic                 dst_valid,
	input  logic                 dst_stall,
	output box_out_t             dst_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int NDIV = QUOT_W + 1;

	logic [CFG_W-1:0] cfg_q [NUM_CFG];
	logic             adv;
	logic             src_acc;

	box_in_t      box_q;
	logic         busy_q;
	logic [2:0]   cnt_q;

	logic signed [31:0] vec [3];
	logic signed [31:0] mel [4][4];

	corner_meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s38;
	logic signed [63:0] prod_s1 [4][4];
	logic signed [64:0] pair_s2 [4][2];
	logic signed [NUM_W-1:0] sum_s3 [4];

	logic [DIVN_W-1:0] n_s4 [3];
	logic [NUM_W-1:0]  d_s4;
	lane_flags_t       flg_s4 [3];

	// index j holds stage s5+j
	corner_meta_t      div_meta_s5 [NDIV];
	logic [NUM_W-1:0]  div_d_s5 [NDIV];
	logic [DIVN_W-1:0] div_rem_s5 [NDIV][3];
	logic [QUOT_W-1:0] div_q_s5 [NDIV][3];
	lane_flags_t       div_flg_s5 [NDIV][3];

	logic signed [31:0] quot_s38 [3];
	logic               fault_s38;

	logic signed [31:0] sat_val [3];
	logic               sat_flt [3];

	logic signed [31:0] min_q [3];
	logic signed [31:0] max_q [3];
	logic               flt_q;
	logic signed [31:0] min_nx [3];
	logic signed [31:0] max_nx [3];
	logic               flt_nx;

	logic     dst_valid_q;
	box_out_t dst_data_q;

	assign cfg_ready = 1'b1;
	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_data_q;

	// the pipe moves whenever the output slot is free or being emptied
	assign adv       = !dst_valid_q || !dst_stall;
	assign src_stall = !(adv && (!busy_q || cnt_q == LAST_CORNER));
	assign src_acc   = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) cfg_q[i] <= CFG_RESET[i];
		end else if (cfg_valid && cfg_ready && cfg_index < CFG_IDX_W'(NUM_CFG)) begin
			cfg_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				mel[r][c] = (c % 2 == 1) ? cfg_q[r*2 + c/2][63:32] : cfg_q[r*2 + c/2][31:0];
			end
		end
		vec[0] = cnt_q[2] ? box_q.max_x : box_q.min_x;
		vec[1] = cnt_q[1] ? box_q.max_y : box_q.min_y;
		vec[2] = cnt_q[0] ? box_q.max_z : box_q.min_z;
	end

	// corner sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (adv) begin
			if (busy_q) cnt_q <= cnt_q + 3'd1;
			if (!busy_q || cnt_q == LAST_CORNER) busy_q <= src_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (src_acc) box_q <= src_data;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1  <= '0;
			meta_s2  <= '0;
			meta_s3  <= '0;
			meta_s4  <= '0;
			meta_s38 <= '0;
			for (int j = 0; j < NDIV; j++) div_meta_s5[j] <= '0;
		end else if (adv) begin
			meta_s1 <= '{valid: busy_q, first: cnt_q == 3'd0, last: cnt_q == LAST_CORNER,
				box_valid: box_q.box_valid};
			meta_s2        <= meta_s1;
			meta_s3        <= meta_s2;
			meta_s4        <= meta_s3;
			div_meta_s5[0] <= meta_s4;
			for (int j = 1; j < NDIV; j++) div_meta_s5[j] <= div_meta_s5[j-1];
			meta_s38 <= div_meta_s5[NDIV-1];
		end
	end

	// products, pair sums, row sums, sign handling
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 3; c++) prod_s1[r][c] <= mel[r][c] * vec[c];
				prod_s1[r][3] <= {{16{mel[r][3][31]}}, mel[r][3], 16'h0000};
				pair_s2[r][0] <= {prod_s1[r][0][63], prod_s1[r][0]}
					+ {prod_s1[r][1][63], prod_s1[r][1]};
				pair_s2[r][1] <= {prod_s1[r][2][63], prod_s1[r][2]}
					+ {prod_s1[r][3][63], prod_s1[r][3]};
				sum_s3[r] <= {pair_s2[r][0][64], pair_s2[r][0]}
					+ {pair_s2[r][1][64], pair_s2[r][1]};
			end
			d_s4 <= sum_s3[3][NUM_W-1] ? -sum_s3[3] : sum_s3[3];
			for (int a = 0; a < 3; a++) begin
				n_s4[a] <= {(sum_s3[a][NUM_W-1] ? -sum_s3[a] : sum_s3[a]), 16'h0000};
				flg_s4[a] <= '{neg: sum_s3[a][NUM_W-1] ^ sum_s3[3][NUM_W-1],
					num_neg: sum_s3[a][NUM_W-1], num_zero: sum_s3[a] == '0,
					den_zero: sum_s3[3] == '0, ovf: 1'b0};
			end
		end
	end

	// overflow check, then one restoring quotient bit per stage
	always_ff @(posedge clk) begin
		if (adv) begin
			div_d_s5[0] <= d_s4;
			for (int a = 0; a < 3; a++) begin
				div_rem_s5[0][a] <= n_s4[a];
				div_q_s5[0][a]   <= '0;
				div_flg_s5[0][a] <= '{neg: flg_s4[a].neg, num_neg: flg_s4[a].num_neg,
					num_zero: flg_s4[a].num_zero, den_zero: flg_s4[a].den_zero,
					ovf: {{(CMP_W-DIVN_W){1'b0}}, n_s4[a]} >= {d_s4, {QUOT_W{1'b0}}}};
			end
			for (int j = 1; j < NDIV; j++) begin
				div_d_s5[j] <= div_d_s5[j-1];
				for (int a = 0; a < 3; a++) begin
					div_flg_s5[j][a] <= div_flg_s5[j-1][a];
					if ({{(CMP_W-DIVN_W){1'b0}}, div_rem_s5[j-1][a]}
						>= ({{QUOT_W{1'b0}}, div_d_s5[j-1]} << (QUOT_W - j))) begin
						div_rem_s5[j][a] <= div_rem_s5[j-1][a]
							- DIVN_W'({{QUOT_W{1'b0}}, div_d_s5[j-1]} << (QUOT_W - j));
						div_q_s5[j][a] <= div_q_s5[j-1][a] | (QUOT_W'(1) << (QUOT_W - j));
					end else begin
						div_rem_s5[j][a] <= div_rem_s5[j-1][a];
						div_q_s5[j][a]   <= div_q_s5[j-1][a];
					end
				end
			end
		end
	end

	// saturate
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			automatic lane_flags_t f = div_flg_s5[NDIV-1][a];
			automatic logic [QUOT_W-1:0] q = div_q_s5[NDIV-1][a];
			if (f.den_zero) begin
				sat_val[a] = f.num_zero ? 32'sd0 : (f.num_neg ? Q_MIN : Q_MAX);
				sat_flt[a] = 1'b1;
			end else if (f.ovf || (f.neg ? q > 32'h8000_0000 : q > 32'h7FFF_FFFF)) begin
				sat_val[a] = f.neg ? Q_MIN : Q_MAX;
				sat_flt[a] = 1'b1;
			end else begin
				sat_val[a] = f.neg ? -$signed(q) : $signed(q);
				sat_flt[a] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) quot_s38[a] <= sat_val[a];
			fault_s38 <= sat_flt[0] | sat_flt[1] | sat_flt[2];
		end
	end

	// reduce over the eight corners
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			min_nx[a] = (meta_s38.first || quot_s38[a] < min_q[a]) ? quot_s38[a] : min_q[a];
			max_nx[a] = (meta_s38.first || quot_s38[a] > max_q[a]) ? quot_s38[a] : max_q[a];
		end
		flt_nx = fault_s38 | (!meta_s38.first && flt_q);
	end

	always_ff @(posedge clk) begin
		if (adv && meta_s38.valid) begin
			for (int a = 0; a < 3; a++) begin
				min_q[a] <= min_nx[a];
				max_q[a] <= max_nx[a];
			end
			flt_q <= flt_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (adv) begin
			dst_valid_q <= meta_s38.valid && meta_s38.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && meta_s38.valid && meta_s38.last) begin
			if (meta_s38.box_valid) begin
				dst_data_q <= '{new_min_x: min_nx[0], new_min_y: min_nx[1],
					new_min_z: min_nx[2], new_max_x: max_nx[0], new_max_y: max_nx[1],
					new_max_z: max_nx[2], result_valid: 1'b1, divide_fault: flt_nx};
			end else begin
				dst_data_q <= '{new_min_x: Q_MAX, new_min_y: Q_MAX, new_min_z: Q_MAX,
					new_max_x: Q_MIN, new_max_y: Q_MIN, new_max_z: Q_MIN,
					result_valid: 1'b0, divide_fault: 1'b0};
			end
		end
	end

	`APT_ASSERT_IMPLY(a_accept_slot, src_valid && !src_stall, !busy_q || cnt_q == LAST_CORNER, "box taken mid-sequence")
	`APT_ASSERT_IMPLY(a_invalid_nofault, dst_valid_q && !dst_data_q.result_valid, !dst_data_q.divide_fault, "fault on invalid box")
	`APT_ASSERT_IMPLY(a_min_le_max, dst_valid_q && dst_data_q.result_valid, dst_data_q.new_min_x <= dst_data_q.new_max_x, "min above max")
	`APT_ASSERT_IMPLY(a_freeze, dst_valid_q && dst_stall, ##1 $stable(meta_s38) && $stable(cnt_q), "pipe moved under stall")

endmodule

@@ bench/tb_aabb_projective_transform.sv @@
// ----------------------------------------------------------------------------
// Box transform testbench
// Drives boxes under random gaps and stalls, predicts each transformed box
// from its own matrix copy and checks every result word field by field.
// ----------------------------------------------------------------------------
import aabbpt_pkg::*;

class box_scoreboard;
	box_out_t pending[$];
	logic [63:0] matrix[8];
	int errors;

	function new();
		for (int i = 0; i < 8; i++) matrix[i] = CFG_RESET[i];
		errors = 0;
	endfunction

	function void write_reg(int idx, logic [63:0] val);
		if (idx < 8) matrix[idx] = val;
	endfunction

	function logic signed [31:0] elem(int r, int c);
		logic [63:0] w;
		w = matrix[r*2 + c/2];
		return (c % 2) ? w[63:32] : w[31:0];
	endfunction

	// truncating signed divide of num*2^16 by den, saturated to 32 bits
	function logic signed [31:0] quot(logic signed [127:0] num, logic signed [127:0] den,
			inout logic fault);
		logic signed [127:0] q;
		if (den == 0) begin
			fault = 1;
			if (num == 0) return 0;
			return (num < 0) ? Q_MIN : Q_MAX;
		end
		q = (num <<< 16) / den;
		if (q > 128'sh7FFF_FFFF || q < -128'sh8000_0000) begin
			fault = 1;
			return (q < 0) ? Q_MIN : Q_MAX;
		end
		return q[31:0];
	endfunction

	function void note_box(box_in_t b);
		box_out_t e;
		logic signed [31:0] lo[3], hi[3], mn[3], mx[3], q;
		logic signed [127:0] v[4], acc[4];
		logic fault;
		lo = '{b.min_x, b.min_y, b.min_z};
		hi = '{b.max_x, b.max_y, b.max_z};
		mn = '{Q_MAX, Q_MAX, Q_MAX};
		mx = '{Q_MIN, Q_MIN, Q_MIN};
		fault = 0;
		if (b.box_valid) begin
			for (int k = 0; k < 8; k++) begin
				v[0] = (k & 4) ? hi[0] : lo[0];
				v[1] = (k & 2) ? hi[1] : lo[1];
				v[2] = (k & 1) ? hi[2] : lo[2];
				v[3] = 65536;
				for (int r = 0; r < 4; r++) begin
					acc[r] = 0;
					for (int c = 0; c < 4; c++)
						acc[r] += 128'(signed'(elem(r, c))) * v[c];
				end
				for (int a = 0; a < 3; a++) begin
					q = quot(acc[a], acc[3], fault);
					if (q < mn[a]) mn[a] = q;
					if (q > mx[a]) mx[a] = q;
				end
			end
		end
		e.new_min_x = mn[0]; e.new_min_y = mn[1]; e.new_min_z = mn[2];
		e.new_max_x = mx[0]; e.new_max_y = mx[1]; e.new_max_z = mx[2];
		e.result_valid = b.box_valid;
		e.divide_fault = fault;
		pending.push_back(e);
	endfunction

	function void check_result(box_out_t got);
		box_out_t e;
		if (pending.size() == 0) begin
			$error("result word with nothing pending");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.new_min_x !== e.new_min_x) begin
			$error("new_min_x exp %h got %h", e.new_min_x, got.new_min_x); errors++; end
		if (got.new_min_y !== e.new_min_y) begin
			$error("new_min_y exp %h got %h", e.new_min_y, got.new_min_y); errors++; end
		if (got.new_min_z !== e.new_min_z) begin
			$error("new_min_z exp %h got %h", e.new_min_z, got.new_min_z); errors++; end
		if (got.new_max_x !== e.new_max_x) begin
			$error("new_max_x exp %h got %h", e.new_max_x, got.new_max_x); errors++; end
		if (got.new_max_y !== e.new_max_y) begin
			$error("new_max_y exp %h got %h", e.new_max_y, got.new_max_y); errors++; end
		if (got.new_max_z !== e.new_max_z) begin
			$error("new_max_z exp %h got %h", e.new_max_z, got.new_max_z); errors++; end
		if (got.result_valid !== e.result_valid) begin
			$error("result_valid exp %b got %b", e.result_valid, got.result_valid); errors++; end
		if (got.divide_fault !== e.divide_fault) begin
			$error("divide_fault exp %b got %b", e.divide_fault, got.divide_fault); errors++; end
	endfunction
endclass

module tb_aabb_projective_transform;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 46;
	localparam longint CYCLE_LIMIT = 2_000_000;

	logic clk = 0;
	logic arst_n = 0;
	logic src_valid = 0;
	logic src_stall;
	box_in_t src_data = '0;
	logic dst_valid;
	logic dst_stall = 0;
	box_out_t dst_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	box_scoreboard board = new();
	longint cycles = 0;
	bit long_stalls = 0;

	aabb_projective_transform u_top (.*);

	always #4 clk = ~clk;

	function automatic int gap_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
	endfunction

	function automatic logic [31:0] coord();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom;
			default: return $urandom_range(0, 20 << 16) - (10 << 16);
		endcase
	endfunction

	function automatic logic [31:0] coef();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 0;
			default: return $urandom_range(0, 4 << 16) - (2 << 16);
		endcase
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stalls, check every accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if (dst_valid && !dst_stall) board.check_result(dst_data);
			if (long_stalls) dst_stall <= ($urandom_range(0, 9) < 6);
			else dst_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	// valid stays high into the next word when there is no gap; drain drops it
	task automatic send_box(box_in_t b);
		int g;
		g = gap_len();
		if (g > 0) begin
			src_valid <= 0;
			repeat (g) @(posedge clk);
		end
		src_valid <= 1;
		src_data <= b;
		do @(posedge clk); while (src_stall);
		board.note_box(b);
	endtask

	task automatic write_reg(int idx, logic [63:0] val);
		cfg_valid <= 1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		src_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic random_box(bit valid_only);
		box_in_t b;
		b.min_x = coord(); b.min_y = coord(); b.min_z = coord();
		b.max_x = coord(); b.max_y = coord(); b.max_z = coord();
		b.box_valid = valid_only ? 1'b1 : ($urandom_range(0, 9) != 0);
		send_box(b);
	endtask

	initial begin
		box_in_t b;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: identity, extremes, invalid, min above max
		b = '{32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000,
			32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 1'b1};
		send_box(b);
		b.box_valid = 0;
		send_box(b);
		send_box('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1});
		send_box('{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1, 1'b1});
		send_box('0);
		drain();

		// zero w: last row cleared
		write_reg(6, 64'h0);
		write_reg(7, 64'h0);
		send_box('{32'hFFFF_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 1'b1});
		send_box('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1});
		drain();

		// overflow: scale by the largest and smallest coefficients
		write_reg(0, {32'h0, 32'h7FFF_FFFF});
		write_reg(7, {32'h0001_0000, 32'h0});
		write_reg(8, 64'hFFFF_FFFF_FFFF_FFFF);
		send_box('{32'h7FFF_FFFF, 32'h1, 32'h1, 32'h7FFF_FFFF, 32'h1, 32'h1, 1'b1});
		drain();
		write_reg(0, {32'h0, 32'h8000_0000});
		send_box('{32'h7FFF_FFFF, 32'h1, 32'h1, 32'h8000_0000, 32'h1, 32'h1, 1'b1});
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			for (int i = 0; i < 8; i++) begin
				if (phase == 0) write_reg(i, CFG_RESET[i]);
				else if (phase == 5) write_reg(i, 64'hFFFF_FFFF_FFFF_FFFF);
				else write_reg(i, {coef(), coef()});
			end
			// keep w mostly positive and non-zero so divides succeed
			if (phase inside {1, 2, 3}) write_reg(7, {32'h0001_0000 + $urandom_range(0, 65536), coef()});
			long_stalls = (phase == 2);
			for (int n = 0; n < 300; n++) random_box(phase != 4);
			drain();
		end
		write_reg(7, 64'h0);
		for (int n = 0; n < 50; n++) random_box(0);
		drain();

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+design
design/aabbpt_pkg.sv
design/aabb_projective_transform.sv
bench/tb_aabb_projective_transform.sv
